### src/encoder_period_speed_counter_macros.svh
// assertion macros for the encoder period speed counter
// no dependencies; included by the top level
`ifndef ENCODER_PERIOD_SPEED_COUNTER_MACROS_SVH
`define ENCODER_PERIOD_SPEED_COUNTER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define EPSC_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define EPSC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");
`else
`define EPSC_ASSERT_IMPL(label, clk, rst, pre, post)
`define EPSC_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

### src/epsc_pkg.sv
// shared types and constants of the encoder period speed counter
// no dependencies
package epsc_pkg;
   localparam int SPEED_W     = 20;
   localparam int TIME_W      = 32;
   localparam int COUNT_W     = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int DIV_STEPS   = SPEED_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   localparam logic [CSR_INDEX_W-1:0] CSR_HAS_CHANNEL_B  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_SEC  = 2'd1;

   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic [SPEED_W-1:0] TICKS_RESET = 20'd1000000;

   // controller to datapath commands
   typedef struct packed {
      logic accept;    // take the request beat
      logic div_step;  // one restoring division step
      logic div_last;  // final step, write the speed
      logic emit;      // load the response register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic need_div;  // request beat needs a division
   } status_type;
endpackage

### src/epsc_ctrl.sv
// controller state machine of the encoder period speed counter
// depends on epsc_pkg
module epsc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  epsc_pkg::status_type status,
   output epsc_pkg::cmd_type    cmd
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [epsc_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        last_step;
   logic                        slot_free;

   assign last_step = (step_ff == epsc_pkg::STEP_W'(epsc_pkg::DIV_STEPS - 1));
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               step_in    = '0;
               state_in   = status.need_div ? ST_DIV : ST_DONE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (last_step) begin
               cmd.div_last = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

### src/epsc_dpath.sv
// datapath: encoder state, config registers, serial divider, response register
// depends on epsc_pkg
module epsc_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  epsc_pkg::cmd_type                   cmd,
   output epsc_pkg::status_type                status,
   input  logic                                csr_valid,
   input  logic [epsc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [epsc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_op,
   input  logic [epsc_pkg::TIME_W-1:0]         req_time_us,
   input  logic                                req_level_a,
   input  logic                                req_level_b,
   input  logic signed [epsc_pkg::COUNT_W-1:0] req_load_value,
   output logic [epsc_pkg::SPEED_W-1:0]        rsp_speed_pps,
   output logic                                rsp_moving_forward,
   output logic signed [epsc_pkg::COUNT_W-1:0] rsp_pulse_count,
   output logic                                rsp_speed_updated
);
   logic                                has_b_ff;
   logic [epsc_pkg::SPEED_W-1:0]        ticks_ff;
   logic                                first_ff;
   logic [epsc_pkg::TIME_W-1:0]         last_ff;
   logic [epsc_pkg::SPEED_W-1:0]        speed_ff;
   logic                                dir_ff;
   logic [epsc_pkg::COUNT_W-1:0]        count_ff;
   logic                                upd_ff;
   logic [epsc_pkg::TIME_W-1:0]         dt_ff;
   logic [epsc_pkg::TIME_W-1:0]         rem_ff;
   logic [epsc_pkg::SPEED_W-1:0]        dvd_ff;
   logic [epsc_pkg::SPEED_W-1:0]        out_speed_ff;
   logic                                out_dir_ff;
   logic [epsc_pkg::COUNT_W-1:0]        out_count_ff;
   logic                                out_upd_ff;

   logic                                dir_in;
   logic [epsc_pkg::TIME_W:0]           trial;
   logic                                fits;
   logic [epsc_pkg::TIME_W-1:0]         rem_in;
   logic [epsc_pkg::SPEED_W-1:0]        dvd_in;

   assign status.need_div = (req_op == epsc_pkg::OP_EDGE) && !first_ff
                            && (req_time_us > last_ff);

   assign dir_in = has_b_ff ? !(req_level_a ^ req_level_b) : dir_ff;

   // restoring step: shift one dividend bit into the remainder
   assign trial  = {rem_ff, dvd_ff[epsc_pkg::SPEED_W-1]} - {1'b0, dt_ff};
   assign fits   = !trial[epsc_pkg::TIME_W];
   assign rem_in = fits ? trial[epsc_pkg::TIME_W-1:0]
                        : {rem_ff[epsc_pkg::TIME_W-2:0], dvd_ff[epsc_pkg::SPEED_W-1]};
   assign dvd_in = {dvd_ff[epsc_pkg::SPEED_W-2:0], fits};

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         has_b_ff <= 1'b1;
         ticks_ff <= epsc_pkg::TICKS_RESET;
      end else if (csr_valid) begin
         if (csr_index == epsc_pkg::CSR_HAS_CHANNEL_B) begin
            has_b_ff <= csr_wdata[0];
         end else if (csr_index == epsc_pkg::CSR_TICKS_PER_SEC) begin
            ticks_ff <= csr_wdata[epsc_pkg::SPEED_W-1:0];
         end
      end
   end

   // encoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         last_ff  <= '0;
         speed_ff <= '0;
         dir_ff   <= 1'b1;
         count_ff <= '0;
      end else begin
         if (cmd.accept) begin
            if (req_op == epsc_pkg::OP_LOAD) begin
               count_ff <= req_load_value;
            end else begin
               first_ff <= 1'b0;
               last_ff  <= req_time_us;
               dir_ff   <= dir_in;
               count_ff <= dir_in ? count_ff + 1'b1 : count_ff - 1'b1;
            end
         end
         if (cmd.div_last) begin
            speed_ff <= dvd_in;
         end
      end
   end

   // divider and flag registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         dt_ff  <= req_time_us - last_ff;
         rem_ff <= '0;
         dvd_ff <= ticks_ff;
         upd_ff <= status.need_div;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         dvd_ff <= dvd_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_speed_ff <= speed_ff;
         out_dir_ff   <= dir_ff;
         out_count_ff <= count_ff;
         out_upd_ff   <= upd_ff;
      end
   end

   assign rsp_speed_pps      = out_speed_ff;
   assign rsp_moving_forward = out_dir_ff;
   assign rsp_pulse_count    = out_count_ff;
   assign rsp_speed_updated  = out_upd_ff;
endmodule

### src/encoder_period_speed_counter.sv
// top level of the encoder period speed counter
// depends on epsc_pkg, epsc_ctrl, epsc_dpath and the macros header
//
// channel   direction  handshake              payload
// req       in         req_valid/req_ready    op, time_us, level_a, level_b, load_value
// rsp       out        rsp_valid/rsp_ready    speed_pps, moving_forward, pulse_count,
//                                             speed_updated
// csr       in         csr_valid/csr_ready    csr_index, csr_wdata
//
// an edge beat that yields a new speed goes through accept, 20 steps of the
// radix-2 restoring divider, then the load of the response register
// other edge beats and load beats go from accept straight to that load
// the response register frees the input side: a new beat is taken while an
// earlier response still waits on rsp_ready
// synchronous active-high reset; no clearing pass, all state is in flip-flops
`include "encoder_period_speed_counter_macros.svh"
module encoder_period_speed_counter (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [epsc_pkg::TIME_W-1:0]         req_time_us,
   input  logic                                req_level_a,
   input  logic                                req_level_b,
   input  logic signed [epsc_pkg::COUNT_W-1:0] req_load_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [epsc_pkg::SPEED_W-1:0]        rsp_speed_pps,
   output logic                                rsp_moving_forward,
   output logic signed [epsc_pkg::COUNT_W-1:0] rsp_pulse_count,
   output logic                                rsp_speed_updated,
   // config write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [epsc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [epsc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   epsc_pkg::cmd_type    cmd;
   epsc_pkg::status_type status;

   // config writes are always taken
   assign csr_ready = 1'b1;

   epsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   epsc_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_op             (req_op),
      .req_time_us        (req_time_us),
      .req_level_a        (req_level_a),
      .req_level_b        (req_level_b),
      .req_load_value     (req_load_value),
      .rsp_speed_pps      (rsp_speed_pps),
      .rsp_moving_forward (rsp_moving_forward),
      .rsp_pulse_count    (rsp_pulse_count),
      .rsp_speed_updated  (rsp_speed_updated)
   );

   // the response register is loaded only when it is empty or being drained
   `EPSC_ASSERT_IMPL(a_emit_slot_free, clock, reset, cmd.emit, !rsp_valid || rsp_ready)
   // an accepted beat makes the block busy in the cycle after it
   `EPSC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // no division step runs while requests are taken
   `EPSC_ASSERT_IMPL(a_no_accept_in_div, clock, reset, cmd.div_step, !req_ready)
endmodule
